// ===== rtl/rrq_pkg.sv =====
package rrq_pkg;

    localparam int unsigned ID_W             = 6;
    localparam int unsigned COUNT_W          = 5;
    localparam int unsigned MARK_IDX_MAX_W   = 10;
    localparam int unsigned QUEUE_DEPTH_DEF  = 16;
    localparam int unsigned THREAD_COUNT_DEF = 64;

    typedef enum logic [1:0] {
        MODE_SPAWN = 2'd0,
        MODE_YIELD = 2'd1,
        MODE_EXIT  = 2'd2,
        MODE_NONE  = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        OUTCOME_NONE     = 2'd0,
        OUTCOME_SWITCHED = 2'd1,
        OUTCOME_KEPT     = 2'd2,
        OUTCOME_IDLE     = 2'd3
    } t_outcome;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EXEC,
        ST_SCHED,
        ST_POP_RD,
        ST_POP_MARK,
        ST_POP_CHECK,
        ST_CUR_RD,
        ST_CUR_CHECK,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [1:0]      mode;
        logic [ID_W-1:0] thread_id;
    } t_rrq_in;

    typedef struct packed {
        logic [1:0]         outcome;
        logic               dropped;
        logic               previous_valid;
        logic [ID_W-1:0]    previous_thread;
        logic               running_valid;
        logic [ID_W-1:0]    running_thread;
        logic [COUNT_W-1:0] queued_count;
    } t_rrq_out;

    // Reduce a thread id modulo the thread count by restoring subtraction
    function automatic logic [MARK_IDX_MAX_W-1:0] f_mark_index(
        input logic [ID_W-1:0] id,
        input int unsigned     count
    );
        logic [ID_W-1:0] rem;
        rem = id;
        for (int k = ID_W - 1; k >= 0; k--) begin
            if (int'(rem) >= int'(count << k)) begin
                rem = rem - ID_W'(count << k);
            end
        end
        return MARK_IDX_MAX_W'(rem);
    endfunction

endpackage

// ===== rtl/rrq_ram.sv =====
module rrq_ram #(
    parameter int unsigned WIDTH = 6,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port
    always_ff @(posedge i_clk) begin
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rrq_sched.sv =====
module rrq_sched #(
    parameter int unsigned QUEUE_DEPTH  = 16,
    parameter int unsigned THREAD_COUNT = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  rrq_pkg::t_rrq_in i_in_data,
    output logic             o_res_valid,
    input  logic             i_res_ready,
    output rrq_pkg::t_rrq_out o_res
);
    import rrq_pkg::*;

    localparam int unsigned PW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
    localparam int unsigned MW = $clog2(THREAD_COUNT);

    t_state             r_state, n_state;
    logic [1:0]         r_mode, n_mode;
    logic [ID_W-1:0]    r_tid, n_tid;
    logic [PW-1:0]      r_rp, n_rp;
    logic [PW-1:0]      r_wp, n_wp;
    logic [CW-1:0]      r_count, n_count;
    logic               r_cur_valid, n_cur_valid;
    logic [ID_W-1:0]    r_cur_id, n_cur_id;
    logic [MW-1:0]      r_clr_addr, n_clr_addr;
    logic [1:0]         r_outcome, n_outcome;
    logic               r_dropped, n_dropped;
    logic               r_prev_valid, n_prev_valid;
    logic [ID_W-1:0]    r_prev_id, n_prev_id;
    logic [ID_W-1:0]    r_pop_id, n_pop_id;

    logic               ring_we;
    logic [ID_W-1:0]    ring_wdata;
    logic [ID_W-1:0]    ring_rdata;
    logic               mark_we;
    logic [MW-1:0]      mark_waddr;
    logic               mark_wdata;
    logic [MW-1:0]      mark_raddr;
    logic               mark_rdata;

    logic [MARK_IDX_MAX_W-1:0] idx_tid_full, idx_cur_full, idx_ring_full;
    logic [MW-1:0]      idx_tid, idx_cur, idx_ring;
    logic               queue_full;

    assign idx_tid_full  = f_mark_index(r_tid, THREAD_COUNT);
    assign idx_cur_full  = f_mark_index(r_cur_id, THREAD_COUNT);
    assign idx_ring_full = f_mark_index(ring_rdata, THREAD_COUNT);
    assign idx_tid       = idx_tid_full[MW-1:0];
    assign idx_cur       = idx_cur_full[MW-1:0];
    assign idx_ring      = idx_ring_full[MW-1:0];
    assign queue_full    = (r_count == CW'(QUEUE_DEPTH));

    // Run queue ring, read always at the head pointer
    rrq_ram #(
        .WIDTH (ID_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (ring_we),
        .i_waddr (r_wp),
        .i_wdata (ring_wdata),
        .i_raddr (r_rp),
        .o_rdata (ring_rdata)
    );

    // Dead mark per thread
    rrq_ram #(
        .WIDTH (1),
        .DEPTH (THREAD_COUNT)
    ) u_marks (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_raddr (mark_raddr),
        .o_rdata (mark_rdata)
    );

    // State and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_rp        <= '0;
            r_wp        <= '0;
            r_count     <= '0;
            r_cur_valid <= 1'b0;
            r_cur_id    <= '0;
            r_clr_addr  <= '0;
        end else begin
            r_state     <= n_state;
            r_rp        <= n_rp;
            r_wp        <= n_wp;
            r_count     <= n_count;
            r_cur_valid <= n_cur_valid;
            r_cur_id    <= n_cur_id;
            r_clr_addr  <= n_clr_addr;
        end
    end

    // Item and result payload
    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_tid        <= n_tid;
        r_outcome    <= n_outcome;
        r_dropped    <= n_dropped;
        r_prev_valid <= n_prev_valid;
        r_prev_id    <= n_prev_id;
        r_pop_id     <= n_pop_id;
    end

    // Next state, memory accesses and result
    always_comb begin
        n_state      = r_state;
        n_mode       = r_mode;
        n_tid        = r_tid;
        n_rp         = r_rp;
        n_wp         = r_wp;
        n_count      = r_count;
        n_cur_valid  = r_cur_valid;
        n_cur_id     = r_cur_id;
        n_clr_addr   = r_clr_addr;
        n_outcome    = r_outcome;
        n_dropped    = r_dropped;
        n_prev_valid = r_prev_valid;
        n_prev_id    = r_prev_id;
        n_pop_id     = r_pop_id;
        ring_we      = 1'b0;
        ring_wdata   = r_tid;
        mark_we      = 1'b0;
        mark_waddr   = r_clr_addr;
        mark_wdata   = 1'b0;
        mark_raddr   = idx_cur;
        o_in_ready   = 1'b0;
        o_res_valid  = 1'b0;

        unique case (r_state)
            ST_CLEAR: begin
                // Sweep every dead mark to alive
                mark_we    = 1'b1;
                n_clr_addr = r_clr_addr + MW'(1);
                if (r_clr_addr == MW'(THREAD_COUNT - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    n_mode       = i_in_data.mode;
                    n_tid        = i_in_data.thread_id;
                    n_outcome    = OUTCOME_NONE;
                    n_dropped    = 1'b0;
                    n_prev_valid = 1'b0;
                    n_prev_id    = '0;
                    n_state      = ST_EXEC;
                end
            end
            ST_EXEC: begin
                unique case (t_mode'(r_mode))
                    MODE_SPAWN: begin
                        mark_we    = 1'b1;
                        mark_waddr = idx_tid;
                        mark_wdata = 1'b0;
                        ring_wdata = r_tid;
                        n_state    = ST_FINISH;
                    end
                    MODE_YIELD: begin
                        ring_wdata = r_cur_id;
                        n_state    = ST_SCHED;
                    end
                    MODE_EXIT: begin
                        mark_we    = r_cur_valid;
                        mark_waddr = idx_cur;
                        mark_wdata = 1'b1;
                        n_state    = ST_SCHED;
                    end
                    default: begin
                        n_state = ST_FINISH;
                    end
                endcase
                // Append to the ring on spawn, or re-append the current thread on yield
                if ((t_mode'(r_mode) == MODE_SPAWN) ||
                    ((t_mode'(r_mode) == MODE_YIELD) && r_cur_valid)) begin
                    if (queue_full) begin
                        n_dropped = 1'b1;
                    end else begin
                        ring_we = 1'b1;
                        n_wp    = (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + PW'(1);
                        n_count = r_count + CW'(1);
                    end
                end
            end
            ST_SCHED: begin
                priority if (r_count != '0) begin
                    n_state = ST_POP_RD;
                end else if (r_cur_valid) begin
                    n_state = ST_CUR_RD;
                end else begin
                    n_outcome = OUTCOME_IDLE;
                    n_state   = ST_FINISH;
                end
            end
            ST_POP_RD: begin
                // Head read issues this cycle; advance the head
                n_rp    = (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + PW'(1);
                n_count = r_count - CW'(1);
                n_state = ST_POP_MARK;
            end
            ST_POP_MARK: begin
                mark_raddr = idx_ring;
                n_pop_id   = ring_rdata;
                n_state    = ST_POP_CHECK;
            end
            ST_POP_CHECK: begin
                if (!mark_rdata) begin
                    n_outcome    = OUTCOME_SWITCHED;
                    n_prev_valid = r_cur_valid;
                    n_prev_id    = r_cur_valid ? r_cur_id : '0;
                    n_cur_valid  = 1'b1;
                    n_cur_id     = r_pop_id;
                    n_state      = ST_FINISH;
                end else begin
                    // Drop the dead entry and keep searching
                    n_state = ST_SCHED;
                end
            end
            ST_CUR_RD: begin
                mark_raddr = idx_cur;
                n_state    = ST_CUR_CHECK;
            end
            ST_CUR_CHECK: begin
                if (r_cur_valid && !mark_rdata) begin
                    n_outcome = OUTCOME_KEPT;
                end else begin
                    n_outcome   = OUTCOME_IDLE;
                    n_cur_valid = 1'b0;
                    n_cur_id    = '0;
                end
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result fields
    always_comb begin
        o_res.outcome         = r_outcome;
        o_res.dropped         = r_dropped;
        o_res.previous_valid  = r_prev_valid;
        o_res.previous_thread = r_prev_id;
        o_res.running_valid   = r_cur_valid;
        o_res.running_thread  = r_cur_valid ? r_cur_id : '0;
        o_res.queued_count    = COUNT_W'(r_count);
    end

endmodule

// ===== rtl/round_robin_run_queue.sv =====
// Channel | Direction | Handshake                | Payload
// in      | input     | i_in_valid / o_in_ready  | i_in_data  (rrq_pkg::t_rrq_in)
// out     | output    | o_out_valid / i_out_ready| o_out_data (rrq_pkg::t_rrq_out)
//
// One item at a time. Spawn and no-op items are accepted, executed and handed off.
// Yield and exit are accepted and executed, then pop ring entries (up to QUEUE_DEPTH),
// each by a ring read followed by the dependent dead-mark read and a check; when the
// ring is dry they finish directly with no current thread, or else once the current
// mark is read and checked. After reset, a clearing pass sweeps the dead-mark memory.
// The output register frees the scheduler; a held result stalls only the next completion.
module round_robin_run_queue #(
    parameter int unsigned QUEUE_DEPTH  = rrq_pkg::QUEUE_DEPTH_DEF,
    parameter int unsigned THREAD_COUNT = rrq_pkg::THREAD_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  rrq_pkg::t_rrq_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output rrq_pkg::t_rrq_out o_out_data
);
    import rrq_pkg::*;

    logic     res_valid;
    logic     res_ready;
    t_rrq_out res;
    logic     r_out_valid;
    t_rrq_out r_out_data;

    rrq_sched #(
        .QUEUE_DEPTH  (QUEUE_DEPTH),
        .THREAD_COUNT (THREAD_COUNT)
    ) u_sched (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res)
    );

    // Load the output register when it is empty or being drained
    assign res_ready = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out_data <= res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
